### hw/rtl/itoa_pkg.sv
// Shared types, constants and the helper function of the radix integer-to-ASCII converter.
package itoa_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 64;
    localparam int STEP_BITS   = 8;
    localparam int STEPS       = VALUE_BITS / STEP_BITS;
    localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W      = $clog2(VALUE_BITS);
    localparam int COUNT_W     = $clog2(VALUE_BITS + 1);
    localparam int POS_W       = $clog2(MAX_DIGITS);
    localparam int TOTAL_W     = $clog2(MAX_DIGITS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int RADIX_W     = 5;
    localparam int MIN_W       = 7;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        logic                  upper_case;
        logic [MIN_W-1:0]      min_digits;
    } itoa_job_t;

    typedef struct packed {
        logic      valid;
        itoa_job_t job;
    } itoa_qlink_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } itoa_back_state_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] digit,
                                                   input logic upper);
        logic [CHAR_W-1:0] res;
        if (digit < DIGIT_W'(10)) begin
            res = CHAR_ZERO + CHAR_W'(digit);
        end
        else if (upper) begin
            res = CHAR_UPPER_A + CHAR_W'(digit) - CHAR_W'(10);
        end
        else begin
            res = CHAR_LOWER_A + CHAR_W'(digit) - CHAR_W'(10);
        end
        return res;
    endfunction

endpackage

### hw/rtl/radix_integer_to_ascii_top.sv
// Top level of the radix integer-to-ASCII converter.
// Each accepted number is printed in its radix (2 to 16, clamped) as ASCII characters, most
// significant first, zero padded to min_digits (saturated at 64), with last on the final
// character. A two-entry input queue takes new numbers while the previous one is converted.
// The shared radix divider produces 8 quotient bits per cycle, and the characters then leave
// one per cycle while out_stall is low, from the registered read port of the 32-entry digit
// memory. No clearing pass follows reset.
module radix_integer_to_ascii_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [itoa_pkg::VALUE_BITS-1:0]   value,
    input  logic [itoa_pkg::RADIX_W-1:0]      radix,
    input  logic                              upper_case,
    input  logic [itoa_pkg::MIN_W-1:0]        min_digits,
    input  logic                              in_valid,
    output logic                              in_stall,
    output logic [itoa_pkg::CHAR_W-1:0]       character,
    output logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall
);

    itoa_pkg::itoa_qlink_t q_link;
    logic                  q_pop;

    itoa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix      (radix),
        .upper_case (upper_case),
        .min_digits (min_digits),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_pop      (q_pop),
        .q_link     (q_link)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_link    (q_link),
        .q_pop     (q_pop),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_link.valid)
        else $error("queue popped while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q_link.valid)
        else $error("accepted transaction missing from queue");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((character >= 8'h30 && character <= 8'h39) ||
                       (character >= 8'h41 && character <= 8'h46) ||
                       (character >= 8'h61 && character <= 8'h66)))
        else $error("output character is not a hex digit");
`endif

endmodule

### hw/rtl/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // return new data when reading the address being written
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/itoa_front.sv
// Front end: accepts numbers, clamps radix and minimum count, and queues them.
module itoa_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [itoa_pkg::VALUE_BITS-1:0]      value,
    input  logic [itoa_pkg::RADIX_W-1:0]         radix,
    input  logic                                 upper_case,
    input  logic [itoa_pkg::MIN_W-1:0]           min_digits,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 q_pop,
    output itoa_pkg::itoa_qlink_t                q_link
);

    itoa_pkg::itoa_job_t                  entry_reg [itoa_pkg::QUEUE_DEPTH];
    logic [itoa_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [itoa_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [itoa_pkg::QFILL_W-1:0]         fill_reg, fill_next;
    itoa_pkg::itoa_job_t                  job_in;
    logic                                 push;

    always_comb
    begin
        job_in.value      = value;
        job_in.upper_case = upper_case;
        if (radix < itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MIN))
        begin
            job_in.radix = itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MIN);
        end
        else if (radix > itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MAX))
        begin
            job_in.radix = itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MAX);
        end
        else
        begin
            job_in.radix = radix;
        end
        if (min_digits > itoa_pkg::MIN_W'(itoa_pkg::MAX_DIGITS))
        begin
            job_in.min_digits = itoa_pkg::MIN_W'(itoa_pkg::MAX_DIGITS);
        end
        else
        begin
            job_in.min_digits = min_digits;
        end
    end

    assign in_stall = (fill_reg == itoa_pkg::QFILL_W'(itoa_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;

    assign q_link.valid = (fill_reg != '0);
    assign q_link.job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

### hw/rtl/itoa_back.sv
// Back end: splits a number into digits with a radix divider, then streams its characters.
module itoa_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  itoa_pkg::itoa_qlink_t            q_link,
    output logic                             q_pop,
    output logic [itoa_pkg::CHAR_W-1:0]      character,
    output logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall
);

    itoa_pkg::itoa_back_state_t           state_reg, state_next;
    logic [itoa_pkg::VALUE_BITS-1:0]      w_reg, w_next;
    logic [itoa_pkg::DIGIT_W-1:0]         rem_reg, rem_next;
    logic [itoa_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [itoa_pkg::RADIX_W-1:0]         radix_reg, radix_next;
    logic                                 upper_reg, upper_next;
    logic [itoa_pkg::MIN_W-1:0]           min_reg, min_next;
    logic [itoa_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [itoa_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [itoa_pkg::CHAR_W-1:0]          char_reg, char_next;
    logic                                 last_reg, last_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [itoa_pkg::RADIX_W-1:0]         trial;
    logic [itoa_pkg::DIGIT_W-1:0]         part;
    logic [itoa_pkg::STEP_BITS-1:0]       qbits;
    logic [itoa_pkg::VALUE_BITS-1:0]      div_w;
    logic [itoa_pkg::DIGIT_W-1:0]         div_rem;
    logic                                 digit_done;
    logic [itoa_pkg::COUNT_W-1:0]         count_inc;
    logic                                 more;
    logic [itoa_pkg::TOTAL_W-1:0]         total;
    logic                                 load;
    logic                                 ram_we;
    logic [itoa_pkg::DIGIT_W-1:0]         ram_rdata;

    // Long division by the radix, STEP_BITS quotient bits per cycle.
    always_comb
    begin
        part  = rem_reg;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < itoa_pkg::STEP_BITS; i++)
        begin
            trial = {part, w_reg[itoa_pkg::VALUE_BITS-1-i]};
            if (trial >= radix_reg)
            begin
                trial = trial - radix_reg;
                qbits[itoa_pkg::STEP_BITS-1-i] = 1'b1;
            end
            part = trial[itoa_pkg::DIGIT_W-1:0];
        end
        div_w   = {w_reg[itoa_pkg::VALUE_BITS-itoa_pkg::STEP_BITS-1:0], qbits};
        div_rem = part;
    end

    assign digit_done = (step_reg == itoa_pkg::STEP_W'(itoa_pkg::STEPS - 1));
    assign count_inc  = count_reg + 1'b1;
    assign more       = (div_w != '0) &&
                        (count_inc < itoa_pkg::COUNT_W'(itoa_pkg::VALUE_BITS));
    assign total      = (itoa_pkg::TOTAL_W'(count_inc) > itoa_pkg::TOTAL_W'(min_reg)) ?
                        itoa_pkg::TOTAL_W'(count_inc) : itoa_pkg::TOTAL_W'(min_reg);
    assign load       = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::BK_IDLE:
            begin
                if (q_link.valid)
                begin
                    state_next = itoa_pkg::BK_DIV;
                end
            end
            itoa_pkg::BK_DIV:
            begin
                if (digit_done && !more)
                begin
                    state_next = itoa_pkg::BK_EMIT;
                end
            end
            itoa_pkg::BK_EMIT:
            begin
                if (load && (pos_reg == '0))
                begin
                    state_next = itoa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        w_next         = w_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        radix_next     = radix_reg;
        upper_next     = upper_reg;
        min_next       = min_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            itoa_pkg::BK_IDLE:
            begin
                if (q_link.valid)
                begin
                    q_pop      = 1'b1;
                    w_next     = q_link.job.value;
                    rem_next   = '0;
                    step_next  = '0;
                    radix_next = q_link.job.radix;
                    upper_next = q_link.job.upper_case;
                    min_next   = q_link.job.min_digits;
                    count_next = '0;
                end
            end
            itoa_pkg::BK_DIV:
            begin
                w_next    = div_w;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (digit_done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_inc;
                    rem_next   = '0;
                    step_next  = '0;
                    if (!more)
                    begin
                        pos_next = itoa_pkg::POS_W'(total - 1'b1);
                    end
                end
            end
            itoa_pkg::BK_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    last_next      = (pos_reg == '0);
                    if (itoa_pkg::COUNT_W'(pos_reg) < count_reg)
                    begin
                        char_next = itoa_pkg::hex_char(ram_rdata, upper_reg);
                    end
                    else
                    begin
                        char_next = itoa_pkg::CHAR_ZERO;
                    end
                    if (pos_reg != '0)
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Read at the next position so the registered data matches pos_reg.
    itoa_ram #(
        .WIDTH (itoa_pkg::DIGIT_W),
        .DEPTH (itoa_pkg::VALUE_BITS)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[itoa_pkg::ADDR_W-1:0]),
        .wdata (div_rem),
        .raddr (pos_next[itoa_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoa_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        upper_reg <= upper_next;
        min_reg   <= min_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

endmodule

### tb/radix_integer_to_ascii_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radix integer-to-ASCII converter.
module radix_integer_to_ascii_top_test;
    import itoa_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam string LOWER_DIGITS = "0123456789abcdef";
    localparam string UPPER_DIGITS = "0123456789ABCDEF";

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } expected_char_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic [VALUE_BITS-1:0] value      = '0;
    logic [RADIX_W-1:0]    radix      = RADIX_W'(10);
    logic                  upper_case = 1'b0;
    logic [MIN_W-1:0]      min_digits = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     character;
    logic                  last;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;

    expected_char_t expected_chars[$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    int             burst_left     = 0;
    bit             gaps_enabled   = 1'b1;
    bit             hold_request   = 1'b0;
    int             hold_left      = 0;
    int             pattern_left   = 0;
    int             stall_mode     = 0;
    int unsigned    stall_phase    = 0;

    radix_integer_to_ascii_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix      (radix),
        .upper_case (upper_case),
        .min_digits (min_digits),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue the characters that one accepted number must produce.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] num,
                                           input logic [RADIX_W-1:0] base_in,
                                           input logic upper,
                                           input logic [MIN_W-1:0] min_in);
        int unsigned           base;
        int unsigned           minimum;
        int unsigned           count;
        int unsigned           total;
        int unsigned           pos;
        logic [VALUE_BITS-1:0] rest;
        logic [DIGIT_W-1:0]    digits [VALUE_BITS];
        expected_char_t        item;
        base = 32'(base_in);
        if (base < RADIX_MIN)
            base = RADIX_MIN;
        if (base > RADIX_MAX)
            base = RADIX_MAX;
        minimum = 32'(min_in);
        if (minimum > MAX_DIGITS)
            minimum = MAX_DIGITS;
        rest  = num;
        count = 0;
        do
        begin
            digits[count] = DIGIT_W'(rest % base);
            count++;
            rest = rest / base;
        end
        while (rest != 0 && count < VALUE_BITS);
        total = (count > minimum) ? count : minimum;
        for (int k = 0; k < total; k++)
        begin
            pos = total - 1 - k;
            if (pos >= count)
                item.code = CHAR_ZERO;
            else if (upper)
                item.code = UPPER_DIGITS[digits[pos]];
            else
                item.code = LOWER_DIGITS[digits[pos]];
            item.is_last = (k == total - 1);
            expected_chars.push_back(item);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one number; hold the payload until the transaction completes.
    task automatic send_number(input logic [VALUE_BITS-1:0] num,
                               input logic [RADIX_W-1:0] base,
                               input logic upper,
                               input logic [MIN_W-1:0] min_count);
        int gap;
        if (gaps_enabled && burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(1, 6);
        end
        @(negedge clk);
        value      = num;
        radix      = base;
        upper_case = upper;
        min_digits = min_count;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digits(num, base, upper, min_count);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_random_number();
        logic [VALUE_BITS-1:0] num;
        logic [RADIX_W-1:0]    base;
        logic [MIN_W-1:0]      min_count;
        num = $urandom;
        num = num >> $urandom_range(0, VALUE_BITS - 1);
        if ($urandom_range(0, 15) == 0)
            num = '0;
        if ($urandom_range(0, 9) == 0)
            base = RADIX_W'($urandom_range(0, 31));
        else
            base = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        case ($urandom_range(0, 9))
            0:       min_count = MIN_W'($urandom_range(MAX_DIGITS + 1, 127));
            1:       min_count = MIN_W'($urandom_range(20, MAX_DIGITS));
            default: min_count = MIN_W'($urandom_range(0, 12));
        endcase
        send_number(num, base, ($urandom_range(0, 1) == 1), min_count);
    endtask

    // Stop offering and wait for every queued character.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_number(32'd0, 5'd10, 1'b0, 7'd0);
        send_number(32'd0, 5'd10, 1'b0, 7'd1);
        send_number(32'd0, 5'd16, 1'b1, 7'd64);
        send_number(32'hFFFF_FFFF, 5'd2, 1'b0, 7'd0);
        send_number(32'hFFFF_FFFF, 5'd16, 1'b0, 7'd0);
        send_number(32'hFFFF_FFFF, 5'd16, 1'b1, 7'd0);
        send_number(32'hFFFF_FFFF, 5'd10, 1'b0, 7'd0);
        send_number(32'hABCD_EF01, 5'd16, 1'b0, 7'd12);
        send_number(32'hABCD_EF01, 5'd16, 1'b1, 7'd8);
        send_number(32'd12345, 5'd10, 1'b0, 7'd127);
        send_number(32'd255, 5'd16, 1'b0, 7'd65);
        // radix below two behaves as binary
        send_number(32'd5, 5'd0, 1'b0, 7'd0);
        send_number(32'd5, 5'd1, 1'b1, 7'd3);
        // radix above sixteen behaves as hex
        send_number(32'd255, 5'd17, 1'b1, 7'd0);
        send_number(32'd48879, 5'd31, 1'b1, 7'd0);
        send_number(32'h8000_0000, 5'd3, 1'b0, 7'd0);
        send_number(32'd12345678, 5'd7, 1'b0, 7'd2);
        send_number(32'd1, 5'd2, 1'b0, 7'd64);
        send_number(32'd7, 5'd8, 1'b0, 7'd5);
        send_number(32'hFEDC_BA98, 5'd16, 1'b1, 7'd0);
        wait_drained();
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count) send_random_number();
        wait_drained();
    endtask

    // Hold the output off while the sender keeps pushing, so the input stalls.
    task automatic test_receiver_hold();
        gaps_enabled = 1'b0;
        hold_request = 1'b1;
        repeat (14) send_random_number();
        gaps_enabled = 1'b1;
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (pattern_left == 0)
        begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        stall_phase++;
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 2) == 0);
                2:       out_stall = (stall_phase % 5 < 2);
                default: out_stall = ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_output
        expected_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                note_mismatch($sformatf("unexpected character %h last %b", character, last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.code || last !== want.is_last)
                    note_mismatch($sformatf("expected char %h last %b, got char %h last %b",
                                            want.code, want.is_last, character, last));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("radix_integer_to_ascii_top_test: done, errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_random_numbers(130);
        test_receiver_hold();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
            note_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        if (mismatch_count == 0)
            $display("radix_integer_to_ascii_top_test: done, clean");
        else
            $display("radix_integer_to_ascii_top_test: done, errors");
        $finish;
    end

endmodule
